FILE: rtl/obl_pkg.sv
// Shared types and constants for the order book level table.
// Used by all modules of the block; no dependencies.
`default_nettype none
package obl_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int PW = 48;
  localparam int IW = 63;

  localparam logic [1:0] MODE_SNAP_START = 2'd0;
  localparam logic [1:0] MODE_SNAP_LEVEL = 2'd1;
  localparam logic [1:0] MODE_UPD_HEADER = 2'd2;
  localparam logic [1:0] MODE_UPD_LEVEL  = 2'd3;

  localparam logic [2:0] ST_APPLIED = 3'd0;
  localparam logic [2:0] ST_STALE   = 3'd1;
  localparam logic [2:0] ST_GAP     = 3'd2;
  localparam logic [2:0] ST_DROPPED = 3'd3;
  localparam logic [2:0] ST_AWAIT   = 3'd4;

  typedef struct packed {
    logic [1:0]    mode;
    logic          side;
    logic [PW-1:0] level_price;
    logic [PW-1:0] level_size;
    logic [IW-1:0] first_id;
    logic [IW-1:0] final_id;
    logic [IW-1:0] previous_final_id;
  } in_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [PW-1:0] best_bid_price;
    logic [PW-1:0] best_bid_size;
    logic [PW-1:0] best_ask_price;
    logic [PW-1:0] best_ask_size;
    logic [6:0]    bid_levels_used;
    logic [6:0]    ask_levels_used;
    logic [IW-1:0] applied_id;
  } out_t;

  // one stored level: price in the upper half, size in the lower
  typedef struct packed {
    logic [PW-1:0] price;
    logic [PW-1:0] size;
  } level_t;

endpackage
`default_nettype wire

FILE: rtl/obl_mem.sv
// Level store of one book side: one write port, one registered read port.
// Depends on obl_pkg for the level type.
`default_nettype none
module obl_mem #(
  parameter int DEPTH = obl_pkg::DEPTH_DEF,
  parameter int AW    = 6
) (
  input  wire                  clk,
  input  wire                  we,
  input  wire [AW-1:0]         waddr,
  input  obl_pkg::level_t      wdata,
  input  wire [AW-1:0]         raddr,
  output obl_pkg::level_t      rdata
);

  obl_pkg::level_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/order_book_level_table_top.sv
// Order book level table: sequencer over two per-side level memories.
// Depends on obl_pkg and obl_mem.
//
// Usage:
//   in_valid/in_ready carry one in_t transaction; out_valid/out_ready carry
//   exactly one out_t result per input transaction, in order.
//   Snapshot start, headers and ignored levels go straight to the result.
//   A level that touches a side scans the sorted store one entry at a time
//   (read then compare; single read port, registered read), then shifts
//   entries one at a time (read then write) on insert or delete, then
//   rereads entry 0 for the best level.
//   One transaction is processed at a time; the next is accepted once the
//   previous result sits in the output register.
//   Reset clears counts, the applied id and the message flag, and sets the
//   book as awaiting a snapshot. Store contents are not cleared; only
//   entries below the count are ever used.
//   If the receiver stalls, the result holds in the output register and the
//   sequencer waits with the next result until it is taken.
module order_book_level_table_top #(
  parameter int DEPTH = obl_pkg::DEPTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_ready,
  input  obl_pkg::in_t in_data,
  output logic         out_valid,
  input  wire          out_ready,
  output obl_pkg::out_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_SCMP   = 4'd2;
  localparam logic [3:0] S_DEC    = 4'd3;
  localparam logic [3:0] S_DEL_RD = 4'd4;
  localparam logic [3:0] S_DEL_WR = 4'd5;
  localparam logic [3:0] S_INS_RD = 4'd6;
  localparam logic [3:0] S_INS_WR = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_FIN2   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]             state_r;
  obl_pkg::in_t           item_r;
  logic [CW-1:0]          pos_r, k_r, n_r;
  logic                   found_r;
  logic [2:0]             status_r;
  logic [CW-1:0]          bid_cnt_r, ask_cnt_r;
  logic [obl_pkg::IW-1:0] last_id_r;
  logic                   msg_acc_r, need_snap_r;
  obl_pkg::level_t        bid_best_r, ask_best_r;
  logic                   out_valid_r;
  obl_pkg::out_t          out_data_r;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  obl_pkg::level_t        mem_wdata, bid_rd, ask_rd, rd;
  logic [CW-1:0]          cur_cnt;
  obl_pkg::level_t        new_lvl;
  logic                   better;
  logic [obl_pkg::IW:0]   next_id;
  logic                   window, chained;

  assign rd      = item_r.side ? ask_rd : bid_rd;
  assign cur_cnt = item_r.side ? ask_cnt_r : bid_cnt_r;
  assign new_lvl = '{price: item_r.level_price, size: item_r.level_size};
  assign better  = item_r.side ? (rd.price < item_r.level_price)
                               : (rd.price > item_r.level_price);

  assign next_id = {1'b0, last_id_r} + 1'b1;
  assign window  = ({1'b0, in_data.first_id} <= next_id) &&
                   (next_id <= {1'b0, in_data.final_id});
  assign chained = (in_data.previous_final_id == last_id_r) &&
                   (in_data.previous_final_id != '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_r[AW-1:0];
    mem_wdata = rd;
    mem_raddr = '0;
    unique case (state_r) inside
      S_SRD:    mem_raddr = pos_r[AW-1:0];
      S_DEL_RD: mem_raddr = AW'(k_r + 1'b1);
      S_INS_RD: begin
        mem_raddr = AW'(k_r - 1'b1);
        if (k_r <= pos_r) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[AW-1:0];
          mem_wdata = new_lvl;
        end
      end
      S_DEC: begin
        if (found_r && item_r.level_size != '0) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[AW-1:0];
          mem_wdata = new_lvl;
        end
      end
      S_DEL_WR, S_INS_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  obl_mem #(.DEPTH(DEPTH), .AW(AW)) u_bid_mem (
    .clk(clk), .we(mem_we && !item_r.side), .waddr(mem_waddr),
    .wdata(mem_wdata), .raddr(mem_raddr), .rdata(bid_rd)
  );

  obl_mem #(.DEPTH(DEPTH), .AW(AW)) u_ask_mem (
    .clk(clk), .we(mem_we && item_r.side), .waddr(mem_waddr),
    .wdata(mem_wdata), .raddr(mem_raddr), .rdata(ask_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      last_id_r   <= '0;
      msg_acc_r   <= 1'b0;
      need_snap_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE owns out_valid_r in its own cycle
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r   <= in_data;
            status_r <= obl_pkg::ST_APPLIED;
            pos_r    <= '0;
            found_r  <= 1'b0;
            state_r  <= S_DONE;
            if (in_data.mode == obl_pkg::MODE_SNAP_START) begin
              bid_cnt_r   <= '0;
              ask_cnt_r   <= '0;
              last_id_r   <= in_data.final_id;
              need_snap_r <= 1'b0;
              msg_acc_r   <= 1'b0;
            end else if (need_snap_r) begin
              status_r <= obl_pkg::ST_AWAIT;
            end else if (in_data.mode == obl_pkg::MODE_SNAP_LEVEL) begin
              if (in_data.level_size != '0) begin
                state_r <= S_SRD;
              end
            end else if (in_data.mode == obl_pkg::MODE_UPD_HEADER) begin
              if (in_data.final_id <= last_id_r) begin
                msg_acc_r <= 1'b0;
                status_r  <= obl_pkg::ST_STALE;
              end else if (window || chained) begin
                last_id_r <= in_data.final_id;
                msg_acc_r <= 1'b1;
              end else begin
                need_snap_r <= 1'b1;
                msg_acc_r   <= 1'b0;
                status_r    <= obl_pkg::ST_GAP;
              end
            end else begin
              if (!msg_acc_r) begin
                status_r <= obl_pkg::ST_STALE;
              end else begin
                state_r <= S_SRD;
              end
            end
          end
        end
        S_SRD: begin
          state_r <= (pos_r >= cur_cnt) ? S_DEC : S_SCMP;
        end
        S_SCMP: begin
          if (better) begin
            pos_r   <= pos_r + 1'b1;
            state_r <= S_SRD;
          end else begin
            found_r <= (rd.price == item_r.level_price);
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          state_r <= S_FIN;
          if (item_r.level_size == '0) begin
            if (found_r) begin
              k_r     <= pos_r;
              state_r <= S_DEL_RD;
            end
          end else if (!found_r) begin
            if (cur_cnt >= DEPTH_C && pos_r >= cur_cnt) begin
              status_r <= obl_pkg::ST_DROPPED;
            end else begin
              n_r     <= (cur_cnt >= DEPTH_C) ? DEPTH_C - 1'b1 : cur_cnt;
              k_r     <= (cur_cnt >= DEPTH_C) ? DEPTH_C - 1'b1 : cur_cnt;
              state_r <= S_INS_RD;
            end
          end
        end
        S_DEL_RD: begin
          if (k_r + 1'b1 >= cur_cnt) begin
            if (item_r.side) ask_cnt_r <= cur_cnt - 1'b1;
            else             bid_cnt_r <= cur_cnt - 1'b1;
            state_r <= S_FIN;
          end else begin
            state_r <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          k_r     <= k_r + 1'b1;
          state_r <= S_DEL_RD;
        end
        S_INS_RD: begin
          if (k_r > pos_r) begin
            state_r <= S_INS_WR;
          end else begin
            if (item_r.side) ask_cnt_r <= n_r + 1'b1;
            else             bid_cnt_r <= n_r + 1'b1;
            state_r <= S_FIN;
          end
        end
        S_INS_WR: begin
          k_r     <= k_r - 1'b1;
          state_r <= S_INS_RD;
        end
        S_FIN: state_r <= S_FIN2;
        S_FIN2: begin
          if (item_r.side) ask_best_r <= rd;
          else             bid_best_r <= rd;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.status          <= status_r;
            out_data_r.best_bid_price  <= (bid_cnt_r != '0) ? bid_best_r.price : '0;
            out_data_r.best_bid_size   <= (bid_cnt_r != '0) ? bid_best_r.size : '0;
            out_data_r.best_ask_price  <= (ask_cnt_r != '0) ? ask_best_r.price : '0;
            out_data_r.best_ask_size   <= (ask_cnt_r != '0) ? ask_best_r.size : '0;
            out_data_r.bid_levels_used <= 7'(bid_cnt_r);
            out_data_r.ask_levels_used <= 7'(ask_cnt_r);
            out_data_r.applied_id      <= last_id_r;
            state_r                    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
